@@ rtl/core/landmark_bearing_localizer_top_defines.svh @@
// Assertion macros for the landmark bearing localizer.
`ifndef LANDMARK_BEARING_LOCALIZER_TOP_DEFINES_SVH
`define LANDMARK_BEARING_LOCALIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LBL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("localizer check failed");

// Next-cycle implication, checked outside reset.
`define LBL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("localizer check failed");

`endif

@@ rtl/core/lbl_pkg.sv @@
// Types, constants and helper functions of the landmark bearing localizer.
package lbl_pkg;

    typedef logic signed [17:0] t_coord;
    typedef logic signed [18:0] t_wide;
    typedef logic signed [14:0] t_trig;

    localparam logic [14:0] FULL_TURN    = 15'd5760;
    localparam logic [14:0] HALF_TURN    = 15'd2880;
    localparam logic [14:0] THREE_QUART  = 15'd4320;
    localparam logic [14:0] QUARTER_TURN = 15'd1440;
    localparam logic [10:0] QUARTER_U    = 11'd1440;

    // Reciprocal of 45 scaled by 2^26; t = (u * RECIP_45) >> 17.
    localparam logic [20:0] RECIP_45   = 21'd1491309;
    localparam logic [20:0] SIN_C1     = 21'd1160;
    localparam logic [14:0] SIN_C2     = 15'd10512;
    localparam logic [14:0] SIN_C3     = 15'd25736;
    localparam logic [28:0] ROUND_HALF = 29'd8192;
    localparam logic [6:0]  CELL_STRIDE = 7'd10;

    localparam logic [2:0] REG_FIRST_X  = 3'd0;
    localparam logic [2:0] REG_FIRST_Y  = 3'd1;
    localparam logic [2:0] REG_SECOND_X = 3'd2;
    localparam logic [2:0] REG_SECOND_Y = 3'd3;
    localparam logic [2:0] REG_CELL     = 3'd4;

    localparam t_coord     RST_FIRST_X  = 18'sd1257;
    localparam t_coord     RST_FIRST_Y  = 18'sd432;
    localparam t_coord     RST_SECOND_X = 18'sd1256;
    localparam t_coord     RST_SECOND_Y = 18'sd2848;
    localparam logic [12:0] RST_CELL    = 13'd432;

    localparam t_wide POS_MAX = 19'sd131071;
    localparam t_wide POS_MIN = -19'sd131072;

    // Clamp a 19-bit signed value into the 18-bit coordinate range.
    function automatic t_coord sat18(input t_wide v);
        t_coord res;
        if (v > POS_MAX) begin
            res = 18'sh1FFFF;
        end else if (v < POS_MIN) begin
            res = 18'sh20000;
        end else begin
            res = v[17:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/landmark_bearing_localizer_top.sv @@
// Landmark bearing localizer: position and ball fix from landmark sightings.
//
// Usage. One input word carries the heading plus bearing, range and a seen
// flag for two fixed landmarks and for the ball. It is taken at a rising edge
// where i_valid is high and o_stall is low. o_stall stays high while a word is
// being worked on. One result word leaves per input word on o_valid/i_stall
// and is taken at an edge where o_valid is high and i_stall is low.
// A shared multiplier is stepped by a small sequencer: each valid sighting
// needs a sine and a cosine (six multiplies each, after the angle is reduced
// by repeated subtraction of a full turn), and a new fix adds a grid search
// for a column index and then a row index, each at most GRID_SPAN - 1.
// The result sits in an output register, so a new word is accepted while the
// previous result still waits; a finished item waits in its last step until
// the output register is free, and no result is ever dropped.
// Configuration is a plain write port (index 0..4: landmark coordinates and
// cell size) and must only be used while the block is idle.
// Synchronous active-low reset restores the default landmark map, clears the
// held position, cell code, fix flag and ball position, and empties the output.
module landmark_bearing_localizer_top #(
    parameter int GRID_SPAN = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [17:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [12:0]         i_heading,
    input  logic [12:0]         i_first_bearing,
    input  logic [12:0]         i_first_range,
    input  logic                i_first_seen,
    input  logic [12:0]         i_second_bearing,
    input  logic [12:0]         i_second_range,
    input  logic                i_second_seen,
    input  logic [12:0]         i_ball_bearing,
    input  logic [12:0]         i_ball_range,
    input  logic                i_ball_seen,
    output logic                o_valid,
    input  logic                i_stall,
    output lbl_pkg::t_coord     o_pos_x,
    output lbl_pkg::t_coord     o_pos_y,
    output logic [6:0]          o_cell_code,
    output logic                o_position_known,
    output lbl_pkg::t_coord     o_ball_x,
    output lbl_pkg::t_coord     o_ball_y
);
    import lbl_pkg::*;
    `include "landmark_bearing_localizer_top_defines.svh"

    localparam int GI_W  = $clog2(GRID_SPAN);
    localparam int ACC_W = GI_W + 13;
    localparam logic [GI_W-1:0] GI_LAST = GI_W'(GRID_SPAN - 1);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SEL  = 4'd1;
    localparam logic [3:0] ST_ANG  = 4'd2;
    localparam logic [3:0] ST_RED  = 4'd3;
    localparam logic [3:0] ST_M0   = 4'd4;
    localparam logic [3:0] ST_M1   = 4'd5;
    localparam logic [3:0] ST_M2   = 4'd6;
    localparam logic [3:0] ST_M3   = 4'd7;
    localparam logic [3:0] ST_M4   = 4'd8;
    localparam logic [3:0] ST_M5   = 4'd9;
    localparam logic [3:0] ST_COMB = 4'd10;
    localparam logic [3:0] ST_FIX  = 4'd11;
    localparam logic [3:0] ST_GRID = 4'd12;
    localparam logic [3:0] ST_FIN  = 4'd13;

    // Sighting slots.
    localparam logic [1:0] K_FIRST  = 2'd0;
    localparam logic [1:0] K_SECOND = 2'd1;
    localparam logic [1:0] K_BALL   = 2'd2;

    // Configuration registers.
    t_coord      r_m1x, r_m1y, r_m2x, r_m2y;
    logic [12:0] r_cell_size;

    // Latched input word.
    logic [12:0] r_head, r_b1, r_r1, r_b2, r_r2, r_bb, r_br;
    logic        r_s1, r_s2, r_sb;

    // Held state.
    t_coord      r_hx, r_hy, r_hbx, r_hby;
    logic [6:0]  r_hcell;
    logic        r_fix;

    // Work registers.
    logic [3:0]  r_state;
    logic [1:0]  r_k;
    logic        r_ph;
    logic [14:0] r_ang;
    logic [10:0] r_u;
    logic        r_neg;
    logic [14:0] r_t, r_t2, r_y;
    t_trig       r_sin, r_cos;
    t_coord      r_x1, r_y1, r_x2, r_y2;
    logic        r_gsel;
    logic [GI_W-1:0]  r_gi, r_col;
    logic [ACC_W-1:0] r_acc;

    // Output register.
    logic        r_ovalid;
    t_coord      r_opx, r_opy, r_obx, r_oby;
    logic [6:0]  r_ocell;
    logic        r_oknown;

    logic [12:0] w_brg, w_rng, w_cs;
    logic [20:0] w_ma;
    logic [14:0] w_mb;
    logic [35:0] w_prod;
    logic [28:0] w_rnd;
    logic [14:0] w_base;
    logic [1:0]  w_q;
    logic [10:0] w_r;
    t_trig       w_scaled;
    t_wide       w_sumx, w_sumy;
    t_coord      w_v;
    logic        w_gdone;
    logic        w_in_acc, w_out_acc;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = r_ovalid && !i_stall;
    assign w_cs      = (r_cell_size == 13'd0) ? 13'd1 : r_cell_size;

    // Per-slot operand selection.
    always_comb begin
        case (r_k)
            K_FIRST:  begin w_brg = r_b1; w_rng = r_r1; end
            K_SECOND: begin w_brg = r_b2; w_rng = r_r2; end
            default:  begin w_brg = r_bb; w_rng = r_br; end
        endcase
    end

    // Quadrant split of a reduced angle.
    always_comb begin
        if (r_ang < QUARTER_TURN) begin
            w_q = 2'd0; w_base = 15'd0;
        end else if (r_ang < HALF_TURN) begin
            w_q = 2'd1; w_base = QUARTER_TURN;
        end else if (r_ang < THREE_QUART) begin
            w_q = 2'd2; w_base = HALF_TURN;
        end else begin
            w_q = 2'd3; w_base = THREE_QUART;
        end
        w_r = 11'(r_ang - w_base);
    end

    // The shared multiplier.
    always_comb begin
        unique case (r_state)
            ST_M0:   begin w_ma = RECIP_45;        w_mb = 15'(r_u);   end
            ST_M1:   begin w_ma = 21'(r_t);        w_mb = r_t;        end
            ST_M2:   begin w_ma = SIN_C1;          w_mb = r_t2;       end
            ST_M3:   begin w_ma = 21'(r_y);        w_mb = r_t2;       end
            ST_M4:   begin w_ma = 21'(r_y);        w_mb = r_t;        end
            ST_M5:   begin w_ma = 21'(r_y);        w_mb = 15'(w_rng); end
            default: begin w_ma = 21'd0;           w_mb = 15'd0;      end
        endcase
    end
    assign w_prod = 36'(w_ma) * 36'(w_mb);
    assign w_rnd  = w_prod[28:0] + ROUND_HALF;
    assign w_scaled = r_neg ? -$signed({1'b0, w_rnd[27:14]}) : $signed({1'b0, w_rnd[27:14]});

    // Pair average, truncated toward zero.
    assign w_sumx = t_wide'(r_x1) + t_wide'(r_x2);
    assign w_sumy = t_wide'(r_y1) + t_wide'(r_y2);

    // Grid search step.
    assign w_v     = r_gsel ? r_hy : r_hx;
    assign w_gdone = w_v[17] || (w_v == 18'sd0) || (r_gi == GI_LAST)
                     || ($unsigned(w_v) < 18'(r_acc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1x <= RST_FIRST_X;
            r_m1y <= RST_FIRST_Y;
            r_m2x <= RST_SECOND_X;
            r_m2y <= RST_SECOND_Y;
            r_cell_size <= RST_CELL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FIRST_X:  r_m1x <= i_cfg_data;
                REG_FIRST_Y:  r_m1y <= i_cfg_data;
                REG_SECOND_X: r_m2x <= i_cfg_data;
                REG_SECOND_Y: r_m2y <= i_cfg_data;
                REG_CELL:     r_cell_size <= i_cfg_data[12:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_head <= i_heading;
            r_b1 <= i_first_bearing;  r_r1 <= i_first_range;  r_s1 <= i_first_seen;
            r_b2 <= i_second_bearing; r_r2 <= i_second_range; r_s2 <= i_second_seen;
            r_bb <= i_ball_bearing;   r_br <= i_ball_range;   r_sb <= i_ball_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_k      <= K_FIRST;
            r_ph     <= 1'b0;
            r_hx     <= '0;
            r_hy     <= '0;
            r_hbx    <= '0;
            r_hby    <= '0;
            r_hcell  <= '0;
            r_fix    <= 1'b0;
            r_ovalid <= 1'b0;
            r_gsel   <= 1'b0;
            r_gi     <= '0;
        end else begin
            if (w_out_acc) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_k     <= K_FIRST;
                        r_state <= ST_SEL;
                    end
                end
                ST_SEL: begin
                    r_ph <= 1'b0;
                    case (r_k)
                        K_FIRST: begin
                            if (r_s1) r_state <= ST_ANG;
                            else r_k <= K_SECOND;
                        end
                        K_SECOND: begin
                            r_state <= r_s2 ? ST_ANG : ST_FIX;
                        end
                        default: begin
                            r_state <= r_sb ? ST_ANG : ST_FIN;
                        end
                    endcase
                end
                ST_ANG: begin
                    r_ang   <= 15'(r_head) + 15'(w_brg) + (r_ph ? QUARTER_TURN : 15'd0);
                    r_state <= ST_RED;
                end
                ST_RED: begin
                    if (r_ang >= FULL_TURN) begin
                        r_ang <= r_ang - FULL_TURN;
                    end else begin
                        r_u     <= w_q[0] ? (QUARTER_U - w_r) : w_r;
                        r_neg   <= w_q[1];
                        r_state <= ST_M0;
                    end
                end
                ST_M0: begin
                    r_t <= w_prod[31:17];
                    r_state <= ST_M1;
                end
                ST_M1: begin
                    r_t2 <= w_prod[28:14];
                    r_state <= ST_M2;
                end
                ST_M2: begin
                    r_y <= SIN_C2 - 15'(w_prod[24:14]);
                    r_state <= ST_M3;
                end
                ST_M3: begin
                    r_y <= SIN_C3 - 15'(w_prod[27:14]);
                    r_state <= ST_M4;
                end
                ST_M4: begin
                    r_y <= w_prod[28:14];
                    r_state <= ST_M5;
                end
                ST_M5: begin
                    if (!r_ph) begin
                        r_sin   <= w_scaled;
                        r_ph    <= 1'b1;
                        r_state <= ST_ANG;
                    end else begin
                        r_cos   <= w_scaled;
                        r_state <= ST_COMB;
                    end
                end
                ST_COMB: begin
                    case (r_k)
                        K_FIRST: begin
                            r_x1 <= sat18(t_wide'(r_m1x) - t_wide'(r_sin));
                            r_y1 <= sat18(t_wide'(r_m1y) + t_wide'(r_cos));
                            r_k  <= K_SECOND;
                            r_state <= ST_SEL;
                        end
                        K_SECOND: begin
                            r_x2 <= sat18(t_wide'(r_m2x) - t_wide'(r_sin));
                            r_y2 <= sat18(t_wide'(r_m2y) + t_wide'(r_cos));
                            r_state <= ST_FIX;
                        end
                        default: begin
                            r_hbx <= sat18(t_wide'(r_hx) + t_wide'(r_sin));
                            r_hby <= sat18(t_wide'(r_hy) - t_wide'(r_cos));
                            r_state <= ST_FIN;
                        end
                    endcase
                end
                ST_FIX: begin
                    r_gsel <= 1'b0;
                    r_gi   <= '0;
                    r_acc  <= ACC_W'(w_cs);
                    if (r_s1 && r_s2) begin
                        r_hx <= 18'((w_sumx + t_wide'({18'd0, w_sumx[18]})) >>> 1);
                        r_hy <= 18'((w_sumy + t_wide'({18'd0, w_sumy[18]})) >>> 1);
                    end else if (r_s1) begin
                        r_hx <= r_x1;
                        r_hy <= r_y1;
                    end else if (r_s2) begin
                        r_hx <= r_x2;
                        r_hy <= r_y2;
                    end
                    if (r_s1 || r_s2) begin
                        r_state <= ST_GRID;
                    end else begin
                        r_k     <= K_BALL;
                        r_state <= ST_SEL;
                    end
                end
                ST_GRID: begin
                    if (w_gdone) begin
                        r_gi  <= '0;
                        r_acc <= ACC_W'(w_cs);
                        if (!r_gsel) begin
                            r_col  <= r_gi;
                            r_gsel <= 1'b1;
                        end else begin
                            r_hcell <= 7'(r_col) * CELL_STRIDE + 7'(r_gi);
                            r_fix   <= 1'b1;
                            r_k     <= K_BALL;
                            r_state <= ST_SEL;
                        end
                    end else begin
                        r_gi  <= r_gi + GI_W'(1);
                        r_acc <= r_acc + ACC_W'(w_cs);
                    end
                end
                ST_FIN: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && (!r_ovalid || !i_stall)) begin
            r_opx    <= r_hx;
            r_opy    <= r_hy;
            r_ocell  <= r_hcell;
            r_oknown <= r_fix;
            r_obx    <= r_hbx;
            r_oby    <= r_hby;
        end
    end

    assign o_stall          = (r_state != ST_IDLE);
    assign o_valid          = r_ovalid;
    assign o_pos_x          = r_opx;
    assign o_pos_y          = r_opy;
    assign o_cell_code      = r_ocell;
    assign o_position_known = r_oknown;
    assign o_ball_x         = r_obx;
    assign o_ball_y         = r_oby;

    `LBL_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, w_in_acc, r_state == ST_SEL)
    `LBL_ASSERT_IMP(a_load_from_fin, i_clk, i_rst_n, $rose(r_ovalid), $past(r_state) == ST_FIN)
    `LBL_ASSERT_IMP(a_quarter_range, i_clk, i_rst_n, r_state == ST_M0, r_u <= QUARTER_U)
    `LBL_ASSERT_IMP(a_grid_bound, i_clk, i_rst_n, r_state == ST_GRID, r_gi <= GI_LAST)

endmodule
